// File: design/rau_pkg.sv
// Rational arithmetic unit: shared types, command codes and status codes.
// No dependencies.
package rau_pkg;
  localparam int WIDTH = 32;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0, CMD_SUB = 3'd1, CMD_MUL = 3'd2, CMD_DIV = 3'd3,
    CMD_NEG = 3'd4, CMD_EQ = 3'd5, CMD_NORM = 3'd6, CMD_NONE = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_ZDEN = 2'd1, ST_OVF = 2'd2, ST_RSV = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } in_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic [1:0]         status;
    logic               is_equal;
  } out_t;
endpackage

// File: design/rau_unit.sv
// Shared iterative unit: binary gcd, then restoring division of num and den by it.
// Depends on rau_pkg.
module rau_unit
  import rau_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [31:0] n_mag,
  input  logic [31:0] d_mag,
  output logic        done,
  output logic [31:0] q_num,
  output logic [31:0] q_den
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_SH = 6'b000010, S_XO = 6'b000100,
    S_LOOP = 6'b001000, S_DIV = 6'b010000, S_FIN = 6'b100000
  } st_t;

  st_t         st_r;
  logic [31:0] x_r, y_r, g_r, nm_r, dm_r, qa_r, qb_r, ra_r, rb_r;
  logic [4:0]  sh_r, cnt_r;
  logic [32:0] ta, tb;
  logic [31:0] ra_s, rb_s;

  always_comb begin
    ra_s = {ra_r[30:0], nm_r[31]};
    rb_s = {rb_r[30:0], dm_r[31]};
    ta = {1'b0, ra_s} - {1'b0, g_r};
    tb = {1'b0, rb_s} - {1'b0, g_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      case (st_r)
        S_IDLE: if (go) begin
          x_r <= n_mag; y_r <= d_mag; nm_r <= n_mag; dm_r <= d_mag;
          sh_r <= '0;
          st_r <= (n_mag == '0) ? S_DIV : S_SH;
          g_r <= d_mag; cnt_r <= '0; ra_r <= '0; rb_r <= '0;
        end
        S_SH: begin
          if (((x_r | y_r) & 32'd1) == '0) begin
            x_r <= x_r >> 1; y_r <= y_r >> 1; sh_r <= sh_r + 5'd1;
          end else st_r <= S_XO;
        end
        S_XO: begin
          if (!x_r[0]) x_r <= x_r >> 1;
          else st_r <= S_LOOP;
        end
        S_LOOP: begin
          if (!y_r[0]) y_r <= y_r >> 1;
          else if (x_r > y_r) begin
            x_r <= y_r; y_r <= x_r - y_r;
            if (x_r - y_r == '0) begin
              g_r <= y_r << sh_r; st_r <= S_DIV;
            end
          end else begin
            y_r <= y_r - x_r;
            if (y_r - x_r == '0) begin
              g_r <= x_r << sh_r; st_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          nm_r <= nm_r << 1; dm_r <= dm_r << 1;
          if (!ta[32]) begin ra_r <= ta[31:0]; qa_r <= {qa_r[30:0], 1'b1}; end
          else begin ra_r <= ra_s; qa_r <= {qa_r[30:0], 1'b0}; end
          if (!tb[32]) begin rb_r <= tb[31:0]; qb_r <= {qb_r[30:0], 1'b1}; end
          else begin rb_r <= rb_s; qb_r <= {qb_r[30:0], 1'b0}; end
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) st_r <= S_FIN;
        end
        S_FIN: st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign done  = (st_r == S_FIN);
  assign q_num = qa_r;
  assign q_den = qb_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(st_r))
    else $error("unit state not one-hot");
  a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_DIV |-> g_r != '0)
    else $error("gcd is zero during division");
  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n) go |-> st_r == S_IDLE)
    else $error("unit started while busy");
endmodule

// File: design/rational_arithmetic_unit_core.sv
// Top level of the rational arithmetic unit: sequencer, products, checks.
// Depends on rau_pkg and rau_unit.
// Compare, unused and zero-denominator commands end in P_M1; a zero divisor and
// intermediate overflow in P_CHK; arithmetic waits in P_RED on the binary gcd
// loop (one shift or subtract a cycle) and the divider. One item at a time;
// busy stays high until the strobe. Synchronous active-low reset returns to idle.
module rational_arithmetic_unit_core
  import rau_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  in_t  in_data,
  output logic busy,
  output logic out_valid,
  output out_t out_data
);
  typedef enum logic [5:0] {
    P_IDLE = 6'b000001, P_M1 = 6'b000010, P_M2 = 6'b000100,
    P_CHK = 6'b001000, P_RED = 6'b010000, P_OUT = 6'b100000
  } pst_t;

  localparam int EW = (WIDTH < 32) ? WIDTH : 32;
  localparam logic signed [65:0] HI = (66'sd1 <<< (EW - 1)) - 66'sd1;
  localparam logic signed [65:0] LO = -HI - 66'sd1;

  pst_t              st_r;
  in_t               in_r;
  logic signed [63:0] p1_r, p2_r, pd_r;
  logic signed [65:0] n_red, d_red;
  logic              neg_r;
  out_t              res_r;
  logic              u_go, u_done;
  logic [31:0]       u_n, u_d, q_n, q_d;
  logic signed [31:0] m1a, m1b, m2a, m2b;
  logic signed [65:0] ns, ds;
  cmd_t              c;

  assign c = cmd_t'(in_r.command);

  always_comb begin
    m1a = in_r.a_num; m1b = in_r.b_den; m2a = in_r.b_num; m2b = in_r.a_den;
    case (c)
      CMD_MUL: begin m1b = in_r.b_num; m2a = in_r.a_den; m2b = in_r.b_den; end
      CMD_DIV: begin m2a = in_r.a_den; m2b = in_r.b_num; end
      default: ;
    endcase
  end

  always_comb begin
    case (c)
      CMD_ADD:  begin ns = 66'(p1_r) + 66'(p2_r); ds = 66'(pd_r); end
      CMD_SUB:  begin ns = 66'(p1_r) - 66'(p2_r); ds = 66'(pd_r); end
      CMD_MUL, CMD_DIV: begin ns = 66'(p1_r); ds = 66'(p2_r); end
      CMD_NEG:  begin ns = -66'(in_r.a_num); ds = 66'(in_r.a_den); end
      default:  begin ns = 66'(in_r.a_num); ds = 66'(in_r.a_den); end
    endcase
  end

  rau_unit u_unit (
    .clk(clk), .rst_n(rst_n), .go(u_go), .n_mag(u_n), .d_mag(u_d),
    .done(u_done), .q_num(q_n), .q_den(q_d)
  );

  assign u_go = (st_r == P_CHK) && (ds != 0) && (ns >= LO) && (ns <= HI)
                && (ds >= LO) && (ds <= HI);
  assign u_n  = (ns < 0) ? 32'(-ns) : 32'(ns);
  assign u_d  = (ds < 0) ? 32'(-ds) : 32'(ds);

  assign n_red = neg_r ? -$signed(66'(q_n)) : $signed(66'(q_n));
  assign d_red = $signed(66'(q_d));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= P_IDLE;
    end else begin
      case (st_r)
        P_IDLE: if (start) begin
          in_r <= in_data; st_r <= P_M1;
        end
        P_M1: begin
          if (c == CMD_NONE) begin
            res_r <= '0; st_r <= P_OUT;
          end else if (c == CMD_EQ) begin
            res_r <= '{res_num: 32'sd0, res_den: 31'd0, status: ST_OK,
                       is_equal: (in_r.a_num == in_r.b_num) && (in_r.a_den == in_r.b_den)};
            st_r <= P_OUT;
          end else if (in_r.a_den == 0 || (c <= CMD_DIV && in_r.b_den == 0)) begin
            res_r <= '{res_num: 32'sd0, res_den: 31'd0, status: ST_ZDEN, is_equal: 1'b0};
            st_r <= P_OUT;
          end else begin
            res_r <= '0;
            p1_r <= 64'(m1a) * 64'(m1b); st_r <= P_M2;
          end
        end
        P_M2: begin
          p2_r <= 64'(m2a) * 64'(m2b); st_r <= P_CHK;
          pd_r <= 64'(in_r.a_den) * 64'(in_r.b_den);
        end
        P_CHK: begin
          neg_r <= (ns < 0) ^ (ds < 0);
          if (ds == 0) begin res_r.status <= ST_ZDEN; st_r <= P_OUT; end
          else if (!u_go) begin res_r.status <= ST_OVF; st_r <= P_OUT; end
          else st_r <= P_RED;
        end
        P_RED: if (u_done) begin
          st_r <= P_OUT;
          if (n_red < LO || n_red > HI || d_red > HI) res_r.status <= ST_OVF;
          else begin
            res_r.res_num <= n_red[31:0]; res_r.res_den <= d_red[30:0];
          end
        end
        P_OUT: st_r <= P_IDLE;
        default: st_r <= P_IDLE;
      endcase
    end
  end

  assign busy      = (st_r != P_IDLE);
  assign out_valid = (st_r == P_OUT);
  assign out_data  = res_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(st_r))
    else $error("sequencer state not one-hot");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && res_r.status != ST_OK |-> res_r.res_num == 0 && res_r.res_den == 0)
    else $error("error result carries a value");
  a_eq_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && res_r.is_equal |-> res_r.status == ST_OK)
    else $error("compare flagged with error");
  a_no_rsv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> res_r.status != ST_RSV)
    else $error("reserved status");
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> busy)
    else $error("strobe while idle");
endmodule

// File: dv/tb.sv
// Testbench for rational_arithmetic_unit_core: directed and random fraction commands,
// checked against an in-bench predictor of the reduced result. Depends on rau_pkg.
`timescale 1ns / 1ps
module tb;
  import rau_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_t  in_data = '0;
  logic busy;
  logic out_valid;
  out_t out_data;

  rational_arithmetic_unit_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .in_data(in_data),
    .busy(busy), .out_valid(out_valid), .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  localparam longint FRAC_HI = 64'sd2147483647;
  localparam longint FRAC_LO = -64'sd2147483648;

  in_t    pending_cmds[$];
  out_t   expected_results[$];
  int     gap_cnt = 0;
  int     n_sent = 0;
  int     n_checked = 0;
  int     n_errors = 0;
  int     n_ok = 0;
  int     n_zden = 0;
  int     n_ovf = 0;
  logic   accepted;

  function automatic bit in_range(longint v);
    return v >= FRAC_LO && v <= FRAC_HI;
  endfunction

  function automatic longint unsigned euclid(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic out_t reduce_frac(longint n, longint d);
    out_t r;
    longint unsigned g;
    r = '0;
    if (d == 0) begin
      r.status = ST_ZDEN;
      return r;
    end
    if (!in_range(n) || !in_range(d)) begin
      r.status = ST_OVF;
      return r;
    end
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    g = euclid((n < 0) ? -n : n, d);
    n = n / longint'(g);
    d = d / longint'(g);
    if (!in_range(n) || d > FRAC_HI) begin
      r.status = ST_OVF;
      return r;
    end
    r.res_num = n[31:0];
    r.res_den = d[30:0];
    r.status  = ST_OK;
    return r;
  endfunction

  function automatic out_t predict_fraction(in_t it);
    out_t   r;
    longint an, ad, bn, bd, p1, p2;
    cmd_t   c;
    r  = '0;
    c  = cmd_t'(it.command);
    an = it.a_num;
    ad = it.a_den;
    bn = it.b_num;
    bd = it.b_den;
    if (c == CMD_NONE) return r;
    if (c == CMD_EQ) begin
      r.is_equal = (an == bn && ad == bd);
      return r;
    end
    if (ad == 0 || (c inside {CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV} && bd == 0)) begin
      r.status = ST_ZDEN;
      return r;
    end
    p1 = an * bd;
    p2 = bn * ad;
    case (c)
      CMD_ADD: begin
        if (p1 > 0 && p2 > 0 && p1 > 64'sh7FFF_FFFF_FFFF_FFFF - p2) begin
          r.status = ST_OVF;
          return r;
        end
        return reduce_frac(p1 + p2, ad * bd);
      end
      CMD_SUB: begin
        if (p2 < 0 && p1 > 64'sh7FFF_FFFF_FFFF_FFFF + p2) begin
          r.status = ST_OVF;
          return r;
        end
        return reduce_frac(p1 - p2, ad * bd);
      end
      CMD_MUL: return reduce_frac(an * bn, ad * bd);
      CMD_DIV: return reduce_frac(p1, ad * bn);
      CMD_NEG: return reduce_frac(-an, ad);
      default: return reduce_frac(an, ad);
    endcase
  endfunction

  function automatic in_t mk(cmd_t c, int an, int ad, int bn, int bd);
    in_t it;
    it.command = c;
    it.a_num = an;
    it.a_den = ad;
    it.b_num = bn;
    it.b_den = bd;
    return it;
  endfunction

  function automatic int rand_field();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $urandom_range(0, 60) - 30;
    if (sel < 6) return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    if (sel < 8) return $urandom_range(0, 131071) - 65536;
    return $urandom;
  endfunction

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // driver: transfer on start && !busy
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_cnt <= 0;
    end else begin
      accepted = start && !busy;
      if (accepted) begin
        expected_results.push_back(predict_fraction(in_data));
        n_sent++;
      end
      if (accepted || !start) begin
        if (gap_cnt > 0) begin
          gap_cnt <= gap_cnt - 1;
          start <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          in_data <= pending_cmds.pop_front();
          start <= 1'b1;
          gap_cnt <= draw_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected result: num=%0d den=%0d st=%0d eq=%0b",
                   out_data.res_num, out_data.res_den, out_data.status, out_data.is_equal);
      end else begin
        exp_r = expected_results.pop_front();
        n_checked++;
        case (status_t'(exp_r.status))
          ST_OK:   n_ok++;
          ST_ZDEN: n_zden++;
          default: n_ovf++;
        endcase
        if (out_data.res_num !== exp_r.res_num || out_data.res_den !== exp_r.res_den ||
            out_data.status !== exp_r.status || out_data.is_equal !== exp_r.is_equal) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch #%0d: exp %0d/%0d st=%0d eq=%0b, got %0d/%0d st=%0d eq=%0b",
                     n_checked, exp_r.res_num, exp_r.res_den, exp_r.status, exp_r.is_equal,
                     out_data.res_num, out_data.res_den, out_data.status, out_data.is_equal);
        end
      end
    end
  end

  initial begin
    int   an, ad, bn, bd;
    cmd_t c;
    pending_cmds.push_back(mk(CMD_ADD, 1, 2, 1, 3));
    pending_cmds.push_back(mk(CMD_SUB, 1, 2, 1, 2));
    pending_cmds.push_back(mk(CMD_MUL, -6, 4, 2, -9));
    pending_cmds.push_back(mk(CMD_DIV, 3, 4, -5, 7));
    pending_cmds.push_back(mk(CMD_NEG, 10, -4, 0, 0));
    pending_cmds.push_back(mk(CMD_EQ, 3, 4, 3, 4));
    pending_cmds.push_back(mk(CMD_EQ, 3, 4, 6, 8));
    pending_cmds.push_back(mk(CMD_NORM, -12, -18, 0, 0));
    pending_cmds.push_back(mk(CMD_ADD, 1, 0, 1, 1));
    pending_cmds.push_back(mk(CMD_MUL, 1, 1, 1, 0));
    pending_cmds.push_back(mk(CMD_NEG, 5, 0, 1, 1));
    pending_cmds.push_back(mk(CMD_NORM, 5, 0, 1, 0));
    pending_cmds.push_back(mk(CMD_DIV, 1, 2, 0, 3));
    pending_cmds.push_back(mk(CMD_NEG, 32'sh8000_0000, 1, 0, 1));
    pending_cmds.push_back(mk(CMD_NORM, 1, 32'sh8000_0000, 0, 1));
    pending_cmds.push_back(mk(CMD_NORM, 0, -7, 0, 1));
    pending_cmds.push_back(mk(CMD_ADD, 32'sh7FFF_FFFF, 1, 32'sh7FFF_FFFF, 1));
    pending_cmds.push_back(mk(CMD_ADD, 32'sh8000_0000, 32'sh8000_0000,
                              32'sh8000_0000, 32'sh8000_0000));
    pending_cmds.push_back(mk(CMD_SUB, 32'sh8000_0000, 32'sh8000_0000,
                              32'sh7FFF_FFFF, 32'sh8000_0000));
    pending_cmds.push_back(mk(CMD_MUL, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                              32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    pending_cmds.push_back(mk(CMD_DIV, 32'sh8000_0000, 1, -1, 1));
    pending_cmds.push_back(mk(CMD_NONE, 32'sh7FFF_FFFF, 3, 4, 5));
    pending_cmds.push_back(mk(CMD_EQ, -1, -1, -1, -1));
    for (int i = 0; i < 500; i++) begin
      c  = cmd_t'($urandom_range(0, 7));
      an = rand_field();
      ad = rand_field();
      bn = rand_field();
      bd = rand_field();
      if (c == CMD_EQ && $urandom_range(0, 1)) begin
        bn = an;
        bd = ad;
      end
      pending_cmds.push_back(mk(c, an, ad, bn, bd));
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_cmds.size() == 0 && !start);
    wait (expected_results.size() == 0);
    repeat (300) @(posedge clk);
    $display("%0d commands sent, %0d results checked", n_sent, n_checked);
    $display("status mix: %0d ok, %0d zero denominator, %0d overflow", n_ok, n_zden, n_ovf);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d errors", n_errors);
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("timeout");
    $display("FAILURE");
    $finish;
  end
endmodule
